// ----- src/itp_pkg.sv -----
// itp_pkg: shared types and constants of the infix to postfix converter
// character codes, operator codes, command kinds, stack sizing
// no dependencies
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_POW   = 8'h5E;

  typedef logic [2:0] op_code_t;
  localparam op_code_t OP_PAREN = 3'd0;
  localparam op_code_t OP_PLUS  = 3'd1;
  localparam op_code_t OP_MINUS = 3'd2;
  localparam op_code_t OP_MUL   = 3'd3;
  localparam op_code_t OP_DIV   = 3'd4;
  localparam op_code_t OP_POW   = 3'd5;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_IGNORE  = 3'd0;
  localparam kind_t KIND_OPERAND = 3'd1;
  localparam kind_t KIND_OPEN    = 3'd2;
  localparam kind_t KIND_OPER    = 3'd3;
  localparam kind_t KIND_CLOSE   = 3'd4;

  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    kind_t      kind;
    op_code_t   code;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic       has;
    err_t       err;
    logic [7:0] ch;
  } res_t;

endpackage

`default_nettype wire

// ----- src/itp_front.sv -----
// itp_front: classifies each incoming character into a stack command
// depends on itp_pkg
`default_nettype none

module itp_front (
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_char,
  input  wire logic          in_last,
  input  wire logic          q_full,
  output logic               in_ready,
  output logic               q_push,
  output itp_pkg::cmd_t      q_data
);
  import itp_pkg::*;

  logic is_alnum;

  always_comb begin
    is_alnum = (in_char inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]});
    q_data.ch   = in_char;
    q_data.last = in_last;
    q_data.code = OP_PAREN;
    q_data.kind = KIND_IGNORE;
    if (is_alnum) begin
      q_data.kind = KIND_OPERAND;
    end else begin
      case (in_char)
        CHAR_OPEN:  q_data.kind = KIND_OPEN;
        CHAR_CLOSE: q_data.kind = KIND_CLOSE;
        CHAR_PLUS: begin
          q_data.kind = KIND_OPER;
          q_data.code = OP_PLUS;
        end
        CHAR_MINUS: begin
          q_data.kind = KIND_OPER;
          q_data.code = OP_MINUS;
        end
        CHAR_MUL: begin
          q_data.kind = KIND_OPER;
          q_data.code = OP_MUL;
        end
        CHAR_DIV: begin
          q_data.kind = KIND_OPER;
          q_data.code = OP_DIV;
        end
        CHAR_POW: begin
          q_data.kind = KIND_OPER;
          q_data.code = OP_POW;
        end
        default: q_data.kind = KIND_IGNORE;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

// ----- src/itp_queue.sv -----
// itp_queue: short command queue between the classifier and the stack engine
// depends on itp_pkg
`default_nettype none

module itp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire itp_pkg::cmd_t push_data,
  input  wire logic          pop,
  output itp_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import itp_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/itp_back.sv -----
// itp_back: operator stack engine, pops and emits one entry per cycle
// while the output is not stalled; holds the output register; depends on itp_pkg
`default_nettype none

module itp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire itp_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output itp_pkg::res_t      out_word
);
  import itp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;

  op_code_t stack_mem [STACK_DEPTH];

  logic [2:0]       state, state_next;
  cmd_t             cmd;
  logic [CNT_W-1:0] count, count_next;
  err_t             error_seen, error_seen_next;
  logic             pend_v, pend_v_next;
  logic [7:0]       pend_ch, pend_ch_next;

  logic             out_free, emit_ok, emit_req;
  logic [7:0]       emit_ch;
  logic             load_out;
  res_t             load_word;
  logic             push_en;
  op_code_t         push_code;
  logic             stack_wr;
  op_code_t         top;
  logic             nonempty, pop_cond;
  logic [2:0]       after;

  function automatic logic [7:0] op_char(input op_code_t c);
    case (c)
      OP_PAREN: op_char = CHAR_OPEN;
      OP_PLUS:  op_char = CHAR_PLUS;
      OP_MINUS: op_char = CHAR_MINUS;
      OP_MUL:   op_char = CHAR_MUL;
      OP_DIV:   op_char = CHAR_DIV;
      OP_POW:   op_char = CHAR_POW;
      default:  op_char = CHAR_OPEN;
    endcase
  endfunction

  function automatic logic [1:0] op_prec(input op_code_t c);
    case (c)
      OP_PLUS, OP_MINUS: op_prec = 2'd1;
      OP_MUL, OP_DIV:    op_prec = 2'd2;
      OP_POW:            op_prec = 2'd3;
      default:           op_prec = 2'd0;
    endcase
  endfunction

  assign top      = stack_mem[PTR_W'(count - 1'b1)];
  assign nonempty = (count != '0);
  assign pop_cond = nonempty && (top != OP_PAREN) &&
                    ((op_prec(top) > op_prec(cmd.code)) ||
                     ((op_prec(top) == op_prec(cmd.code)) && (top != OP_POW)));
  assign out_free = !out_valid || out_ready;
  assign emit_ok  = cmd.last ? (!pend_v || out_free) : out_free;
  assign after    = cmd.last ? S_FLUSH : S_IDLE;
  assign stack_wr = push_en && (count < CNT_W'(STACK_DEPTH));

  always_comb begin
    state_next      = state;
    count_next      = count;
    error_seen_next = error_seen;
    pend_v_next     = pend_v;
    pend_ch_next    = pend_ch;
    q_pop           = 1'b0;
    emit_req        = 1'b0;
    emit_ch         = cmd.ch;
    load_out        = 1'b0;
    load_word       = '{last: 1'b0, has: 1'b1, err: ERR_NONE, ch: pend_ch};
    push_en         = 1'b0;
    push_code       = cmd.code;

    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd.kind)
          KIND_OPERAND: begin
            emit_req = 1'b1;
            if (emit_ok) state_next = after;
          end
          KIND_OPEN: begin
            push_en    = 1'b1;
            push_code  = OP_PAREN;
            state_next = after;
          end
          KIND_OPER: begin
            if (pop_cond) begin
              emit_req = 1'b1;
              emit_ch  = op_char(top);
              if (emit_ok) count_next = count - 1'b1;
            end else begin
              push_en    = 1'b1;
              state_next = after;
            end
          end
          KIND_CLOSE: begin
            if (!nonempty) begin
              if (error_seen == ERR_NONE) error_seen_next = ERR_UNMATCHED;
              state_next = after;
            end else if (top == OP_PAREN) begin
              count_next = count - 1'b1;
              state_next = after;
            end else begin
              emit_req = 1'b1;
              emit_ch  = op_char(top);
              if (emit_ok) count_next = count - 1'b1;
            end
          end
          default: state_next = after;
        endcase
      end
      S_FLUSH: begin
        if (!nonempty) begin
          state_next = S_FINAL;
        end else if (top == OP_PAREN) begin
          count_next = count - 1'b1;
        end else begin
          emit_req = 1'b1;
          emit_ch  = op_char(top);
          if (emit_ok) count_next = count - 1'b1;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          load_out        = 1'b1;
          load_word       = '{last: 1'b1, has: pend_v, err: error_seen,
                              ch: pend_v ? pend_ch : 8'h00};
          pend_v_next     = 1'b0;
          count_next      = '0;
          error_seen_next = ERR_NONE;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (push_en) begin
      if (count < CNT_W'(STACK_DEPTH)) begin
        count_next = count + 1'b1;
      end else if (error_seen == ERR_NONE) begin
        error_seen_next = ERR_OVERFLOW;
      end
    end

    // end-of-expression results are held back in the pending register to mark the last one
    if (emit_req && emit_ok) begin
      if (cmd.last) begin
        load_out     = pend_v;
        pend_v_next  = 1'b1;
        pend_ch_next = emit_ch;
      end else begin
        load_out  = 1'b1;
        load_word = '{last: 1'b0, has: 1'b1, err: ERR_NONE, ch: emit_ch};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stack_wr) begin
      stack_mem[PTR_W'(count)] <= push_code;
    end
    if (q_pop) begin
      cmd <= q_head;
    end
    if (load_out) begin
      out_word <= load_word;
    end
    pend_ch <= pend_ch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      error_seen <= ERR_NONE;
      pend_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      error_seen <= error_seen_next;
      pend_v     <= pend_v_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/infix_to_postfix_converter.sv -----
// infix_to_postfix_converter: top level, classifier, command queue, stack engine
// depends on itp_pkg, itp_front, itp_queue, itp_back
// a character word is written into the queue on acceptance; the engine pops it into
// its command register when idle, and any result it gives is registered on the way out
// the engine takes a new word only once it is through with the last, popping stack
// entries as it goes; an end word also flushes the stack and closes out the expression
// reset clears the queue, stack count, error state and output valid
`default_nettype none

module infix_to_postfix_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  wire logic        s_axis_tlast,   // end_of_expr
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [9:8] error_code, rest zero
  output logic             m_axis_tuser,   // has_char
  output logic             m_axis_tlast    // is_last
);
  import itp_pkg::*;

  cmd_t q_in, q_head;
  logic q_push, q_pop, q_empty, q_full;
  res_t res;

  itp_front u_front (
    .in_valid (s_axis_tvalid),
    .in_char  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  itp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  itp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (res)
  );

  assign m_axis_tdata = {6'b000000, res.err, res.ch};
  assign m_axis_tuser = res.has;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ----- src/itp_checker.sv -----
// itp_checker: port-level checks of the infix to postfix converter
// bound to infix_to_postfix_converter; depends on itp_pkg
`default_nettype none

module itp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import itp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
    else $error("bare word that is not an end marker");

  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[9:8] == ERR_NONE)
    else $error("error code on a word that is not last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
// tb: self-checking bench for infix_to_postfix_converter, a shunting-yard stream block
// drives infix characters, predicts the postfix words with its own operator stack
// depends on itp_pkg and infix_to_postfix_converter
`timescale 1ns / 1ps

module tb;
  import itp_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } infix_word_t;

  typedef struct {
    logic [7:0] ch;
    logic       has;
    logic       last;
    err_t       err;
  } postfix_word_t;

  typedef enum {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  infix_word_t   infix_q[$];
  postfix_word_t postfix_q[$];
  infix_word_t   next_word;
  postfix_word_t want;
  idle_phase_t   phase = PH_FREE;
  bit            word_taken = 1'b0;
  int            hold_left = 0;
  int            miss_cnt = 0;
  int            word_cnt = 0;

  // predictor state
  op_code_t      op_stk[STACK_DEPTH];
  int            op_depth = 0;
  err_t          err_first = ERR_NONE;

  infix_to_postfix_converter dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic bit oper_of(input logic [7:0] ch, output op_code_t code);
    code = OP_PAREN;
    case (ch)
      CHAR_PLUS:  code = OP_PLUS;
      CHAR_MINUS: code = OP_MINUS;
      CHAR_MUL:   code = OP_MUL;
      CHAR_DIV:   code = OP_DIV;
      CHAR_POW:   code = OP_POW;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic int rank(input op_code_t code);
    case (code)
      OP_PLUS, OP_MINUS: return 1;
      OP_MUL, OP_DIV:    return 2;
      OP_POW:            return 3;
      default:           return 0;
    endcase
  endfunction

  function automatic logic [7:0] sym(input op_code_t code);
    case (code)
      OP_PLUS:  return CHAR_PLUS;
      OP_MINUS: return CHAR_MINUS;
      OP_MUL:   return CHAR_MUL;
      OP_DIV:   return CHAR_DIV;
      OP_POW:   return CHAR_POW;
      default:  return CHAR_OPEN;
    endcase
  endfunction

  function automatic bit is_operand(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") || (ch >= "0" && ch <= "9");
  endfunction

  task automatic push_op(input op_code_t code);
    if (op_depth >= STACK_DEPTH) begin
      if (err_first == ERR_NONE) err_first = ERR_OVERFLOW;
    end else begin
      op_stk[op_depth] = code;
      op_depth++;
    end
  endtask

  // shunting-yard step: one infix character in, its postfix words queued
  task automatic shunt_char(input logic [7:0] ch, input logic eoe);
    postfix_word_t outs[$];
    op_code_t      code;
    op_code_t      top;
    int            p;
    bit            matched;
    if (is_operand(ch)) begin
      outs.push_back('{ch: ch, has: 1'b1, last: 1'b0, err: ERR_NONE});
    end else if (ch == CHAR_OPEN) begin
      push_op(OP_PAREN);
    end else if (oper_of(ch, code)) begin
      p = rank(code);
      while (op_depth > 0) begin
        top = op_stk[op_depth - 1];
        if (top == OP_PAREN || rank(top) < p || (rank(top) == p && top == OP_POW)) break;
        outs.push_back('{ch: sym(top), has: 1'b1, last: 1'b0, err: ERR_NONE});
        op_depth--;
      end
      push_op(code);
    end else if (ch == CHAR_CLOSE) begin
      matched = 1'b0;
      while (op_depth > 0) begin
        top = op_stk[op_depth - 1];
        op_depth--;
        if (top == OP_PAREN) begin
          matched = 1'b1;
          break;
        end
        outs.push_back('{ch: sym(top), has: 1'b1, last: 1'b0, err: ERR_NONE});
      end
      if (!matched && err_first == ERR_NONE) err_first = ERR_UNMATCHED;
    end
    if (eoe) begin
      while (op_depth > 0) begin
        top = op_stk[op_depth - 1];
        op_depth--;
        if (top != OP_PAREN)
          outs.push_back('{ch: sym(top), has: 1'b1, last: 1'b0, err: ERR_NONE});
      end
      if (outs.size() == 0) begin
        outs.push_back('{ch: 8'h00, has: 1'b0, last: 1'b1, err: err_first});
      end else begin
        outs[outs.size() - 1].last = 1'b1;
        outs[outs.size() - 1].err = err_first;
      end
      op_depth = 0;
      err_first = ERR_NONE;
    end
    foreach (outs[i]) postfix_q.push_back(outs[i]);
  endtask

  task automatic note_miss(input string msg);
    if (miss_cnt < 10) $display("%s", msg);
    miss_cnt++;
  endtask

  // stimulus
  task automatic add_word(input logic [7:0] ch, input logic last);
    infix_q.push_back('{ch: ch, last: last});
    if (ch != " " || last) word_cnt++;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_word(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(2))
      0:       return 8'h41 + 8'($urandom_range(25));
      1:       return 8'h61 + 8'($urandom_range(25));
      default: return 8'h30 + 8'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(4))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_MUL;
      3:       return CHAR_DIV;
      default: return CHAR_POW;
    endcase
  endfunction

  task automatic mark_end();
    if ($urandom_range(5) == 0)
      add_word($urandom_range(1) ? 8'h20 : 8'h3F, 1'b1);
    else
      infix_q[infix_q.size() - 1].last = 1'b1;
  endtask

  // mostly well formed, now and then a stray or missing paren or a dangling operator
  task automatic gen_expr();
    int terms;
    int depth;
    int i;
    terms = $urandom_range(1, 8);
    depth = 0;
    for (i = 0; i < terms; i++) begin
      while ($urandom_range(3) == 0 && depth < 6) begin
        add_word(CHAR_OPEN, 1'b0);
        depth++;
      end
      add_word(rand_operand(), 1'b0);
      if ($urandom_range(4) == 0) add_word(" ", 1'b0);
      while (depth > 0 && $urandom_range(2) == 0) begin
        add_word(CHAR_CLOSE, 1'b0);
        depth--;
      end
      if ($urandom_range(15) == 0) add_word(CHAR_CLOSE, 1'b0);
      if (i < terms - 1 || $urandom_range(11) == 0) add_word(rand_oper(), 1'b0);
    end
    if ($urandom_range(7) != 0)
      while (depth > 0) begin
        add_word(CHAR_CLOSE, 1'b0);
        depth--;
      end
    mark_end();
  endtask

  // nesting deep enough to run the operator stack past its depth
  task automatic gen_deep();
    int n;
    int i;
    n = $urandom_range(17, 24);
    for (i = 0; i < n; i++) begin
      add_word(rand_operand(), 1'b0);
      add_word(rand_oper(), 1'b0);
      add_word(CHAR_OPEN, 1'b0);
    end
    add_word(rand_operand(), 1'b0);
    if ($urandom_range(1))
      for (i = 0; i < $urandom_range(1, n + 3); i++) add_word(CHAR_CLOSE, 1'b0);
    mark_end();
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(4, 10);
    repeat (n) add_word(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  task automatic fill_random(input int target);
    int start;
    start = word_cnt;
    while (word_cnt - start < target) begin
      case ($urandom_range(19))
        0, 1:    gen_noise();
        2:       gen_deep();
        default: gen_expr();
      endcase
    end
  endtask

  task automatic settle();
    int guard;
    while (infix_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    guard = 0;
    while (postfix_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic int src_idle_pct();
    case (phase)
      PH_SRC_IDLE: return 58;
      PH_BOTH:     return 17;
      default:     return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct();
    case (phase)
      PH_SNK_STALL: return 58;
      PH_BOTH:      return 17;
      default:      return 0;
    endcase
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (infix_q.size() != 0 && $urandom_range(99) >= src_idle_pct()) begin
        next_word = infix_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_word.ch;
        s_axis_tlast <= next_word.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off right after reset
  always @(posedge clk) begin
    if (rst) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk) begin
    m_axis_tready <= !rst && hold_left == 0 && $urandom_range(99) >= snk_stall_pct();
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        shunt_char(s_axis_tdata, s_axis_tlast);
        word_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (postfix_q.size() == 0) begin
          note_miss($sformatf("unexpected word: data=%h user=%b last=%b",
                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = postfix_q.pop_front();
          if (m_axis_tdata[7:0] !== want.ch || m_axis_tdata[9:8] !== want.err ||
              m_axis_tdata[15:10] !== 6'b0 || m_axis_tuser !== want.has ||
              m_axis_tlast !== want.last)
            note_miss($sformatf(
              "bad word: exp ch=%h err=%0d has=%b last=%b, got data=%h has=%b last=%b",
              want.ch, want.err, want.has, want.last,
              m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end
      end
    end
  end

  initial begin
    phase = PH_FREE;
    add_text("a*b-c+d");
    add_text("(A-9)/z");
    add_text("a^b^c");
    add_text("x)");
    add_text("(0");
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(" ", 1'b1);
    fill_random(15);
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    settle();
    phase = PH_SRC_IDLE;
    fill_random(30);
    settle();
    phase = PH_SNK_STALL;
    gen_deep();
    fill_random(30);
    settle();
    phase = PH_BOTH;
    fill_random(30);
    settle();
    repeat (40) @(posedge clk);
    if (postfix_q.size() != 0)
      note_miss($sformatf("%0d expected words never arrived", postfix_q.size()));
    if (miss_cnt == 0)
      $display("infix_to_postfix_converter: match");
    else
      $display("infix_to_postfix_converter: mismatch");
    $finish;
  end

  initial begin
    #(64'd20 * 64'd500000);
    $display("infix_to_postfix_converter: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
src/itp_pkg.sv
src/itp_front.sv
src/itp_queue.sv
src/itp_back.sv
src/infix_to_postfix_converter.sv
src/itp_checker.sv
test/tb.sv
